### hw/rtl/sponge_hash_512_core_assert.svh
// Assertion macros for the sponge hash core.
// Used by modules that check their own control logic; expects clk_i and rst_ni.
`ifndef SPONGE_HASH_512_CORE_ASSERT_SVH
`define SPONGE_HASH_512_CORE_ASSERT_SVH

// Check a property on the core clock, ignored while reset is held.
`define SH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on the core clock, ignored while reset is held.
`define SH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sh512_pkg.sv
// Shared types, constants and byte functions of the sponge hash core.
// No dependencies.
package sh512_pkg;

  localparam int unsigned NUM_ROUNDS  = 24;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned WORD_BITS   = 64;

  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] INIT_BYTE = 8'h02;

  localparam logic [1:0] SHUF_WORD = 2'd0;
  localparam logic [1:0] SHUF_QUAD = 2'd1;
  localparam logic [1:0] SHUF_PAIR = 2'd2;

  typedef struct packed {
    logic [63:0] message_word;
    logic [6:0]  bits_valid;
    logic        last_item;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic [63:0] word;
    logic [6:0]  nbits;
    logic        last;
  } q_item_t;

  typedef logic [255:0][7:0] st_t;
  typedef logic [15:0][63:0] blk_t;
  typedef logic [7:0][63:0]  rc_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FIN,
    ST_LEN,
    ST_PERM,
    ST_OUT
  } back_state_e;

  localparam logic [3:0] S4 [16] = '{
    4'd9, 4'd0, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd15,
    4'd1, 4'd10, 4'd2, 4'd6, 4'd7, 4'd5, 4'd8, 4'd14
  };

  function automatic rc_t rc_init();
    rc_t r;
    r[0] = 64'h243f6a8885a308d3;
    r[1] = 64'h13198a2e03707344;
    r[2] = 64'ha4093822299f31d0;
    r[3] = 64'h082efa98ec4e6c89;
    r[4] = 64'h452821e638d01377;
    r[5] = 64'hbe5466cf34e90c6c;
    r[6] = 64'hc0ac29b7c97c50dd;
    r[7] = 64'h3f84d5b5b5470917;
    return r;
  endfunction

  function automatic logic [63:0] rc_next(logic [63:0] x);
    return {x[60:0], x[63:61]} ^ {x[56:0], x[63:57]} ^ {x[51:0], x[63:52]};
  endfunction

  function automatic logic [7:0] sub_byte(logic [7:0] x);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = x[7:4] ^ S4[x[3:0]];
    b = x[3:0] ^ S4[a];
    c = a ^ S4[b];
    return {b, c};
  endfunction

  function automatic logic [7:0] dbl(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  // Source byte of destination byte i for each rotation pattern.
  function automatic int shuffle_src(logic [1:0] mode, int i);
    int w;
    int ww;
    int q;
    int src;
    w = i / 32;
    case (mode)
      SHUF_WORD: begin
        src = (i - i % 4) + ((i % 4 + w % 4) % 4);
      end
      SHUF_QUAD: begin
        src = (i - i % 16) + ((i % 16 + 4 * (w % 4)) % 16);
      end
      default: begin
        if (w < 4) begin
          ww = w;
          q  = i % 32;
        end else begin
          ww = w - 4;
          q  = i % 32 + 32;
        end
        q = (q + 16 * ww) % 64;
        src = (q < 32) ? (ww * 32 + q) : ((ww + 4) * 32 + q - 32);
      end
    endcase
    return src;
  endfunction

endpackage

### hw/rtl/sh512_front.sv
// Input stage: accepts message words, masks the last word and sizes it.
// Depends on sh512_pkg.
module sh512_front
  import sh512_pkg::*;
(
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output q_item_t  item_o,
  input  logic     q_ready_i
);

  logic [6:0]  nb;
  logic [63:0] mask;

  always_comb begin
    if (!in_item_i.last_item) begin
      nb = 7'(WORD_BITS);
    end else if (in_item_i.bits_valid > 7'(WORD_BITS)) begin
      nb = 7'(WORD_BITS);
    end else begin
      nb = in_item_i.bits_valid;
    end
    for (int i = 0; i < 64; i++) begin
      mask[63 - i] = (7'(i) < nb);
    end
  end

  assign in_ready_o   = q_ready_i;
  assign push_o       = in_valid_i && q_ready_i;
  assign item_o.word  = in_item_i.message_word & mask;
  assign item_o.nbits = nb;
  assign item_o.last  = in_item_i.last_item;

endmodule

### hw/rtl/sh512_queue.sv
// Short FIFO between the input stage and the absorb engine.
// Depends on sh512_pkg.
module sh512_queue
  import sh512_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    ready_o,
  output logic    valid_o,
  output q_item_t item_o,
  input  logic    pop_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_item_t       mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign ready_o = (cnt_q != CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/sh512_round.sv
// One permutation round: key add (when rkey_en_i is set), byte substitution, column mix, rotation.
// Depends on sh512_pkg.
module sh512_round
  import sh512_pkg::*;
(
  input  st_t        st_i,
  input  logic       rkey_en_i,
  input  rc_t        rc_i,
  input  logic [1:0] mode_i,
  output st_t        st_o
);

  st_t keyed, subbed, mixed;

  always_comb begin
    logic [7:0] a, b, c, d, a2, b2, c2, d2;
    keyed = st_i;
    if (rkey_en_i) begin
      for (int j = 0; j < 8; j++) begin
        for (int k = 0; k < 8; k++) begin
          keyed[j * 8 + k] = st_i[j * 8 + k] ^ rc_i[j][63 - 8 * k -: 8];
        end
      end
    end
    for (int i = 0; i < 256; i++) begin
      subbed[i] = sub_byte(keyed[i]);
    end
    for (int h = 0; h < 2; h++) begin
      for (int j = 0; j < 32; j++) begin
        a  = subbed[h * 128 + j];
        b  = subbed[h * 128 + 32 + j];
        c  = subbed[h * 128 + 64 + j];
        d  = subbed[h * 128 + 96 + j];
        a2 = dbl(a);
        b2 = dbl(b);
        c2 = dbl(c);
        d2 = dbl(d);
        mixed[h * 128 + j]      = a2 ^ b2 ^ b ^ c ^ d;
        mixed[h * 128 + 32 + j] = a ^ b2 ^ c2 ^ c ^ d;
        mixed[h * 128 + 64 + j] = a ^ b ^ c2 ^ d2 ^ d;
        mixed[h * 128 + 96 + j] = a2 ^ a ^ b ^ c ^ d2;
      end
    end
    for (int i = 0; i < 256; i++) begin
      case (mode_i)
        SHUF_WORD: st_o[i] = mixed[shuffle_src(SHUF_WORD, i)];
        SHUF_QUAD: st_o[i] = mixed[shuffle_src(SHUF_QUAD, i)];
        default:   st_o[i] = mixed[shuffle_src(SHUF_PAIR, i)];
      endcase
    end
  end

endmodule

### hw/rtl/sh512_back.sv
// Absorb engine: block buffer, bit counter, 2048-bit state, round sequencer
// and digest output register. Depends on sh512_pkg, sh512_round and the assertion header.
`include "sponge_hash_512_core_assert.svh"
module sh512_back
  import sh512_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  q_item_t   q_item_i,
  output logic      q_ready_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_ready_i
);

  back_state_e state_q, state_d, ret_q, ret_d;
  st_t         st_q, st_d, rnd_out;
  blk_t        buf_q, buf_d;
  logic [3:0]  pos_q, pos_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [4:0]  round_q, round_d;
  logic [1:0]  mod3_q, mod3_d;
  rc_t         rc_q, rc_d;
  logic [2:0]  k_q, k_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  function automatic st_t absorb(st_t s, blk_t blk);
    st_t r;
    r = s;
    for (int b = 0; b < 128; b++) begin
      if (b < 64) begin
        r[b] = r[b] ^ blk[b / 8][63 - 8 * (b % 8) -: 8];
      end else begin
        r[b + 64] = r[b + 64] ^ blk[b / 8][63 - 8 * (b % 8) -: 8];
      end
    end
    return r;
  endfunction

  sh512_round u_round (
    .st_i      (st_q),
    .rkey_en_i (round_q[1:0] == 2'd0),
    .rc_i      (rc_q),
    .mode_i    (mod3_q),
    .st_o      (rnd_out)
  );

  always_comb begin
    blk_t        blk;
    logic [63:0] dw;
    state_d     = state_q;
    ret_d       = ret_q;
    st_d        = st_q;
    buf_d       = buf_q;
    pos_d       = pos_q;
    bitlen_d    = bitlen_q;
    round_d     = round_q;
    mod3_d      = mod3_q;
    rc_d        = rc_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    q_ready_o   = 1'b0;
    blk         = buf_q;
    dw          = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_INIT: begin
        st_d     = '0;
        st_d[0]  = INIT_BYTE;
        buf_d    = '0;
        pos_d    = '0;
        bitlen_d = '0;
        ret_d    = ST_IDLE;
        state_d  = ST_PERM;
      end
      ST_PERM: begin
        st_d    = rnd_out;
        round_d = round_q + 1'b1;
        mod3_d  = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 1'b1;
        if (round_q[1:0] == 2'd3) begin
          for (int j = 0; j < 8; j++) begin
            rc_d[j] = rc_next(rc_q[j]);
          end
        end
        if (round_q == 5'(NUM_ROUNDS - 1)) begin
          state_d = ret_q;
        end
      end
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          blk[pos_q] = q_item_i.word;
          bitlen_d   = bitlen_q + 64'(q_item_i.nbits);
          if (pos_q == 4'(BLOCK_WORDS - 1)) begin
            st_d    = absorb(st_q, blk);
            buf_d   = '0;
            pos_d   = '0;
            ret_d   = q_item_i.last ? ST_FIN : ST_IDLE;
            state_d = ST_PERM;
          end else begin
            buf_d = blk;
            pos_d = pos_q + 1'b1;
            if (q_item_i.last) begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_FIN: begin
        if (pos_q != '0 && bitlen_q[9:0] != '0) begin
          st_d    = absorb(st_q, buf_q);
          buf_d   = '0;
          pos_d   = '0;
          ret_d   = ST_LEN;
          state_d = ST_PERM;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        blk     = '0;
        blk[15] = bitlen_q;
        st_d    = absorb(st_q, blk);
        k_d     = '0;
        ret_d   = ST_OUT;
        state_d = ST_PERM;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          for (int b = 0; b < 8; b++) begin
            dw[63 - 8 * b -: 8] = st_q[{2'b00, k_q, 3'(b)}];
          end
          out_valid_d       = 1'b1;
          out_d.digest_word = dw;
          out_d.word_index  = k_q;
          out_d.last_word   = (k_q == 3'd7);
          k_d               = k_q + 1'b1;
          if (k_q == 3'd7) begin
            state_d = ST_INIT;
          end
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
    if (state_d == ST_PERM && state_q != ST_PERM) begin
      round_d = '0;
      mod3_d  = '0;
      rc_d    = rc_init();
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q    <= ret_d;
    st_q     <= st_d;
    buf_q    <= buf_d;
    pos_q    <= pos_d;
    bitlen_q <= bitlen_d;
    round_q  <= round_d;
    mod3_q   <= mod3_d;
    rc_q     <= rc_d;
    k_q      <= k_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SH_ASSERT_IMP(a_round_range, state_q == ST_PERM, round_q <= 5'(NUM_ROUNDS - 1),
                 "round counter past last round")
  `SH_ASSERT(a_init_to_perm, (state_q == ST_INIT) |=> (state_q == ST_PERM),
             "init did not start the permutation")
  `SH_ASSERT(a_out_done, (state_q == ST_OUT && k_q == 3'd7 && (!out_valid_q || out_ready_i))
             |=> (state_q == ST_INIT && out_valid_q && out_q.last_word),
             "digest end did not restart the state")

endmodule

### hw/rtl/sponge_hash_512_core.sv
// 512-bit sponge hash core: input stage, FIFO, absorb engine with one round per cycle.
// Words are taken while the absorb engine is idle; each full block is then permuted in the
// round unit, and the engine takes no words meanwhile. After a last word, a partly filled
// block is absorbed and permuted, then the bit length is absorbed and permuted, then 8 digest
// words follow. Reset and the end of each digest start a rebuild of the initial state; words
// queue in the FIFO meanwhile. Depends on sh512_pkg and all sh512_* modules.
module sponge_hash_512_core
  import sh512_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic    push, q_ready, q_valid, q_pop;
  q_item_t f_item, q_item;

  sh512_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .item_o     (f_item),
    .q_ready_i  (q_ready)
  );

  sh512_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  sh512_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_ready_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_ready_i (out_ready_i)
  );

endmodule
